// File: hdl/rsh_pkg.sv
// Shared types and constants of the ray / segment hit detector.
// No dependencies; used by rsh_prod_sign and ray_segment_hit_detector.

package rsh_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int CFG_INDEX_WIDTH = 2;

	// Reset values of the ray points
	localparam int ORIGIN_X_RST  = 0;
	localparam int ORIGIN_Y_RST  = 0;
	localparam int THROUGH_X_RST = 1;
	localparam int THROUGH_Y_RST = 0;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ORIGIN_X  = 2'd0,
		REG_ORIGIN_Y  = 2'd1,
		REG_THROUGH_X = 2'd2,
		REG_THROUGH_Y = 2'd3
	} cfg_reg_t;

	// a*b - c*d or a*b + c*d
	typedef enum logic {
		OP_SUB = 1'b0,
		OP_ADD = 1'b1
	} op_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sign_t;

	function automatic logic sign_pos(input sign_t s);
		return !s.neg && !s.zero;
	endfunction

endpackage

// File: hdl/rsh_prod_sign.sv
// Pipelined sign of a*b -/+ c*d over signed operands, three register stages.
// Depends on rsh_pkg (op_t, sign_t).

module rsh_prod_sign #(
	parameter int OPER_WIDTH = rsh_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                         clk,
	input  logic                         en,
	input  rsh_pkg::op_t                 op,
	input  logic signed [OPER_WIDTH-1:0] a,
	input  logic signed [OPER_WIDTH-1:0] b,
	input  logic signed [OPER_WIDTH-1:0] c,
	input  logic signed [OPER_WIDTH-1:0] d,
	output rsh_pkg::sign_t               sgn
);

	localparam int LoW  = OPER_WIDTH / 2;
	localparam int HiW  = OPER_WIDTH - LoW;
	localparam int ProdW = 2 * OPER_WIDTH;
	localparam int SumW  = ProdW + 1;

	// operand halves: signed high part, unsigned low part
	logic signed [HiW-1:0] a_hi, b_hi, c_hi, d_hi;
	logic        [LoW-1:0] a_lo, b_lo, c_lo, d_lo;

	assign a_hi = a[OPER_WIDTH-1:LoW];
	assign b_hi = b[OPER_WIDTH-1:LoW];
	assign c_hi = c[OPER_WIDTH-1:LoW];
	assign d_hi = d[OPER_WIDTH-1:LoW];
	assign a_lo = a[LoW-1:0];
	assign b_lo = b[LoW-1:0];
	assign c_lo = c[LoW-1:0];
	assign d_lo = d[LoW-1:0];

	// stage 1: partial products
	logic signed [2*HiW-1:0]   ab_hh_s1, cd_hh_s1;
	logic signed [HiW+LoW:0]   ab_hl_s1, ab_lh_s1, cd_hl_s1, cd_lh_s1;
	logic        [2*LoW-1:0]   ab_ll_s1, cd_ll_s1;
	rsh_pkg::op_t              op_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ab_hh_s1 <= a_hi * b_hi;
			ab_hl_s1 <= a_hi * $signed({1'b0, b_lo});
			ab_lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
			ab_ll_s1 <= a_lo * b_lo;
			cd_hh_s1 <= c_hi * d_hi;
			cd_hl_s1 <= c_hi * $signed({1'b0, d_lo});
			cd_lh_s1 <= $signed({1'b0, c_lo}) * d_hi;
			cd_ll_s1 <= c_lo * d_lo;
			op_s1    <= op;
		end
	end

	// stage 2: full products
	logic signed [ProdW-1:0] ab_s2, cd_s2;
	rsh_pkg::op_t            op_s2;
	logic        [ProdW-1:0] ab_sum, cd_sum;

	always_comb begin
		ab_sum = (ProdW'(ab_hh_s1) << (2 * LoW)) + (ProdW'(ab_hl_s1) << LoW)
		       + (ProdW'(ab_lh_s1) << LoW) + ProdW'(ab_ll_s1);
		cd_sum = (ProdW'(cd_hh_s1) << (2 * LoW)) + (ProdW'(cd_hl_s1) << LoW)
		       + (ProdW'(cd_lh_s1) << LoW) + ProdW'(cd_ll_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s2 <= $signed(ab_sum);
			cd_s2 <= $signed(cd_sum);
			op_s2 <= op_s1;
		end
	end

	// stage 3: combine and take the sign
	logic signed [SumW-1:0] res;
	rsh_pkg::sign_t         sgn_s3;

	always_comb begin
		unique case (op_s2)
			rsh_pkg::OP_ADD: res = SumW'(ab_s2) + SumW'(cd_s2);
			rsh_pkg::OP_SUB: res = SumW'(ab_s2) - SumW'(cd_s2);
			default:         res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s3.neg  <= res[SumW-1];
			sgn_s3.zero <= (res == '0);
		end
	end

	assign sgn = sgn_s3;

endmodule

// File: hdl/ray_segment_hit_detector.sv
// Ray / segment hit detector top level: config registers, control pipeline,
// hit decision, sticky batch flag and result register.
// Depends on rsh_pkg and rsh_prod_sign.
//
//  channel | dir | handshake              | beat contents
//  --------+-----+------------------------+------------------------------------------
//  seg     | in  | seg_valid / seg_stall  | seg_start_x/y, seg_end_x/y, last_segment
//  hit     | out | hit_valid / hit_stall  | hit (one beat per batch, on last segment)
//  cfg     | in  | cfg_we                 | cfg_index, cfg_data (ray origin / through)
//
// One segment beat per cycle while seg_stall is low. The last segment of a batch
// passes the input register, difference stage, three stages of the cross / dot
// product units, then the result register.
// Reset clears valids, the sticky flag and loads the default ray (0,0)->(1,0).
// seg_stall rises only when a finished result is waiting in the result
// register under hit_stall and a second result is ready right behind it.

module ray_segment_hit_detector #(
	parameter int COORD_WIDTH = rsh_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [rsh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data,

	input  logic                                seg_valid,
	output logic                                seg_stall,
	input  logic signed [COORD_WIDTH-1:0]       seg_start_x,
	input  logic signed [COORD_WIDTH-1:0]       seg_start_y,
	input  logic signed [COORD_WIDTH-1:0]       seg_end_x,
	input  logic signed [COORD_WIDTH-1:0]       seg_end_y,
	input  logic                                last_segment,

	output logic                                hit_valid,
	input  logic                                hit_stall,
	output logic                                hit
);

	// differences of two coordinates need one extra bit
	localparam int OperW = COORD_WIDTH + 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] origin_x_q, origin_y_q, through_x_q, through_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= COORD_WIDTH'(rsh_pkg::ORIGIN_X_RST);
			origin_y_q  <= COORD_WIDTH'(rsh_pkg::ORIGIN_Y_RST);
			through_x_q <= COORD_WIDTH'(rsh_pkg::THROUGH_X_RST);
			through_y_q <= COORD_WIDTH'(rsh_pkg::THROUGH_Y_RST);
		end else if (cfg_we) begin
			unique case (rsh_pkg::cfg_reg_t'(cfg_index))
				rsh_pkg::REG_ORIGIN_X:  origin_x_q  <= $signed(cfg_data);
				rsh_pkg::REG_ORIGIN_Y:  origin_y_q  <= $signed(cfg_data);
				rsh_pkg::REG_THROUGH_X: through_x_q <= $signed(cfg_data);
				rsh_pkg::REG_THROUGH_Y: through_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline advance: hold everything only when a second result would
	// collide with one still waiting at the output.
	// ---------------------------------------------------------------
	logic adv;
	logic s5_valid, s5_last, s5_degen;
	logic hit_valid_q, hit_q;

	assign adv       = !(s5_valid && s5_last && hit_valid_q && hit_stall);
	assign seg_stall = !adv;

	// stage 1: input register
	logic                          s1_valid, s1_last;
	logic signed [COORD_WIDTH-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && seg_valid) begin
			ax_s1   <= seg_start_x;
			ay_s1   <= seg_start_y;
			bx_s1   <= seg_end_x;
			by_s1   <= seg_end_y;
			s1_last <= last_segment;
		end
	end

	// stage 2: ray direction, endpoints relative to origin, segment direction
	logic                    s2_valid, s2_last, s2_degen;
	logic signed [OperW-1:0] dx_s2, dy_s2, pax_s2, pay_s2, pbx_s2, pby_s2, ex_s2, ey_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_last  <= s1_last;
			s2_degen <= (through_x_q == origin_x_q) && (through_y_q == origin_y_q);
			dx_s2    <= OperW'(through_x_q) - OperW'(origin_x_q);
			dy_s2    <= OperW'(through_y_q) - OperW'(origin_y_q);
			pax_s2   <= OperW'(ax_s1) - OperW'(origin_x_q);
			pay_s2   <= OperW'(ay_s1) - OperW'(origin_y_q);
			pbx_s2   <= OperW'(bx_s1) - OperW'(origin_x_q);
			pby_s2   <= OperW'(by_s1) - OperW'(origin_y_q);
			ex_s2    <= OperW'(bx_s1) - OperW'(ax_s1);
			ey_s2    <= OperW'(by_s1) - OperW'(ay_s1);
		end
	end

	// stages 3..5: product signs, control carried alongside
	rsh_pkg::sign_t o1, o2, dot1, dot2, tnum, tden;

	// orientation of endpoint A: cross(d, A - origin)
	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_orient_a (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_SUB),
		.a(dx_s2), .b(pay_s2), .c(dy_s2), .d(pax_s2), .sgn(o1)
	);

	// orientation of endpoint B: cross(d, B - origin)
	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_orient_b (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_SUB),
		.a(dx_s2), .b(pby_s2), .c(dy_s2), .d(pbx_s2), .sgn(o2)
	);

	// collinear case: is A or B ahead of the origin along d
	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_dot_a (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_ADD),
		.a(dx_s2), .b(pax_s2), .c(dy_s2), .d(pay_s2), .sgn(dot1)
	);

	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_dot_b (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_ADD),
		.a(dx_s2), .b(pbx_s2), .c(dy_s2), .d(pby_s2), .sgn(dot2)
	);

	// crossing case: ray parameter t = cross(A-o, e) / cross(d, e)
	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_t_num (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_SUB),
		.a(pax_s2), .b(ey_s2), .c(pay_s2), .d(ex_s2), .sgn(tnum)
	);

	rsh_prod_sign #(.OPER_WIDTH(OperW)) u_t_den (
		.clk(clk), .en(adv), .op(rsh_pkg::OP_SUB),
		.a(dx_s2), .b(ey_s2), .c(dy_s2), .d(ex_s2), .sgn(tden)
	);

	logic s3_valid, s3_last, s3_degen;
	logic s4_valid, s4_last, s4_degen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
			s4_valid <= 1'b0;
			s5_valid <= 1'b0;
		end else if (adv) begin
			s3_valid <= s2_valid;
			s4_valid <= s3_valid;
			s5_valid <= s4_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s3_last  <= s2_last;
			s3_degen <= s2_degen;
			s4_last  <= s3_last;
			s4_degen <= s3_degen;
			s5_last  <= s4_last;
			s5_degen <= s4_degen;
		end
	end

	// ---------------------------------------------------------------
	// Hit decision
	// ---------------------------------------------------------------
	logic same_side, on_line, seg_hit, hit_any, hit_seen_q;

	always_comb begin
		same_side = (rsh_pkg::sign_pos(o1) && rsh_pkg::sign_pos(o2))
		          || (o1.neg && o2.neg);
		on_line   = o1.zero && o2.zero;
		priority if (s5_degen || same_side) begin
			seg_hit = 1'b0;
		end else if (on_line) begin
			seg_hit = !dot1.neg || !dot2.neg;
		end else begin
			// t >= 0: numerator or denominator zero, or equal signs
			seg_hit = tnum.zero || tden.zero || (tnum.neg == tden.neg);
		end
		hit_any = hit_seen_q || seg_hit;
	end

	// sticky flag, cleared by the last segment of a batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_seen_q <= 1'b0;
		end else if (adv && s5_valid) begin
			hit_seen_q <= s5_last ? 1'b0 : hit_any;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else if (adv && s5_valid && s5_last) begin
			hit_valid_q <= 1'b1;
		end else if (!hit_stall) begin
			hit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s5_valid && s5_last) begin
			hit_q <= hit_any;
		end
	end

	assign hit_valid = hit_valid_q;
	assign hit       = hit_q;

`ifndef SYNTHESIS
	// input is held off only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> (hit_valid_q && hit_stall && s5_valid && s5_last))
		else $error("seg_stall without a blocked result");

	// the last segment of a batch always leaves the flag clear
	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s5_valid && s5_last) |=> !hit_seen_q)
		else $error("sticky flag not cleared at batch end");

	// a new result comes only from a retiring last segment
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_valid_q && !$past(hit_valid_q)) |-> $past(adv && s5_valid && s5_last))
		else $error("result without a last segment");

	// a degenerate ray never raises the flag
	a_degen_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s5_valid && s5_degen && !s5_last && !hit_seen_q) |=> !hit_seen_q)
		else $error("degenerate ray produced a hit");
`endif

endmodule
